@@ sv/wad_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the int8 window average pool.
// No dependencies; every other file of the block imports this package.
package wad_pkg;

    localparam int SAMPLE_W       = 8;
    localparam int PROD_W         = 16;
    localparam int SUM_W          = 32;
    localparam int SHIFT_W        = 5;
    localparam int SIDE_REG_W     = 5;
    localparam int SIDE_CMP_W     = 7;
    localparam int QDEPTH         = 2;
    localparam int QPTR_W         = 1;
    localparam int QCNT_W         = 2;
    localparam int DIV_STEPS      = 32;
    localparam int SCALE_FRAC_TOP = 25;
    localparam int EXTRA_SHIFT    = 6;

    localparam logic signed [SAMPLE_W-1:0] OUT_MAX     = 8'sh7f;
    localparam logic signed [SAMPLE_W-1:0] OUT_MIN     = 8'sh80;
    localparam logic signed [SAMPLE_W-1:0] OUT_MIN_SYM = 8'sh81;
    localparam logic [SAMPLE_W-1:0]        SCALE_MAX   = 8'd127;
    localparam logic [SAMPLE_W-1:0]        SCALE_RESET = 8'd1;
    localparam logic [SHIFT_W-1:0]         SHIFT_RESET = 5'd2;

    typedef enum logic [2:0] {
        REG_HEIGHT   = 3'd0,
        REG_WIDTH    = 3'd1,
        REG_MODE     = 3'd2,
        REG_SCALE    = 3'd3,
        REG_SHIFT    = 3'd4,
        REG_BIAS     = 3'd5,
        REG_SYM      = 3'd6
    } reg_index_t;

    typedef struct packed {
        logic                first;
        logic                last;
        logic                sym;
        logic [SHIFT_W-1:0]  shift;
        logic [SUM_W-1:0]    start;
    } item_ctl_t;

    typedef struct packed {
        logic                busy;
        logic [SAMPLE_W-1:0] scale;
        logic [SHIFT_W-1:0]  shift;
    } derive_t;

endpackage

@@ sv/wad_derive.sv @@
`timescale 1ns / 1ps
// Derives scale and shift from the pooling window area with a bit-serial divider.
// Depends on wad_pkg.
module wad_derive
    import wad_pkg::*;
#(
    parameter int MAX_WINDOW_SIDE = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [SIDE_REG_W-1:0] height,
    input  logic [SIDE_REG_W-1:0] width,
    output derive_t               result
);

    localparam int SIDE_W = $clog2(MAX_WINDOW_SIDE + 1);
    localparam int AREA_W = 2 * SIDE_W;
    localparam int C_W    = $clog2(AREA_W + 1);
    localparam int CNT_W  = $clog2(DIV_STEPS);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_AREA = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_FIN  = 4'b1000
    } derive_state_t;

    derive_state_t        state_reg, state_next;
    logic [AREA_W-1:0]    area_reg;
    logic [AREA_W-1:0]    rem_reg;
    logic [SUM_W-1:0]     quo_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [SAMPLE_W-1:0]  scale_reg, scale_next;
    logic [SHIFT_W-1:0]   shift_reg, shift_next;

    logic [SIDE_W-1:0]    side_h, side_w;
    logic [AREA_W:0]      trial;
    logic                 trial_ge;
    logic [AREA_W-1:0]    area_m1;
    logic [C_W-1:0]       c_val;
    logic                 pow2;
    logic [SHIFT_W-1:0]   q_val;
    logic [SUM_W:0]       rounded;

    function automatic logic [SIDE_W-1:0] clamp_side(input logic [SIDE_REG_W-1:0] s);
        logic [SIDE_CMP_W-1:0] ext;
        logic [SIDE_CMP_W-1:0] lim;
        ext = SIDE_CMP_W'(s);
        lim = SIDE_CMP_W'(MAX_WINDOW_SIDE);
        if (ext == '0) begin
            return SIDE_W'(1);
        end else if (ext > lim) begin
            return SIDE_W'(lim);
        end
        return SIDE_W'(ext);
    endfunction

    assign side_h   = clamp_side(height);
    assign side_w   = clamp_side(width);
    assign trial    = {rem_reg, (cnt_reg == '0)};
    assign trial_ge = (trial >= {1'b0, area_reg});
    assign area_m1  = area_reg - AREA_W'(1);
    assign pow2     = ((area_reg & area_m1) == '0);

    always_comb begin
        c_val = '0;
        for (int i = 0; i < AREA_W; i++) begin
            if (area_m1[i]) begin
                c_val = C_W'(i + 1);
            end
        end
    end

    assign q_val   = SHIFT_W'(SCALE_FRAC_TOP) - SHIFT_W'(c_val);
    assign rounded = ({1'b0, quo_reg} + ((SUM_W + 1)'(1) << (q_val - SHIFT_W'(1)))) >> q_val;

    always_comb begin
        scale_next = scale_reg;
        shift_next = shift_reg;
        if (state_reg == ST_FIN) begin
            if (pow2) begin
                scale_next = SAMPLE_W'(1);
                shift_next = SHIFT_W'(c_val);
            end else begin
                scale_next = (rounded > (SUM_W + 1)'(SCALE_MAX)) ? SCALE_MAX
                                                                : rounded[SAMPLE_W-1:0];
                shift_next = SHIFT_W'(c_val) + SHIFT_W'(EXTRA_SHIFT);
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: state_next = ST_IDLE;
            ST_AREA: state_next = ST_DIV;
            ST_DIV: begin
                if (cnt_reg == CNT_W'(DIV_STEPS - 1)) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:  state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
        if (start) begin
            state_next = ST_AREA;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            scale_reg <= SCALE_RESET;
            shift_reg <= SHIFT_RESET;
        end else begin
            state_reg <= state_next;
            scale_reg <= scale_next;
            shift_reg <= shift_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_AREA) begin
            area_reg <= AREA_W'(side_h) * AREA_W'(side_w);
            rem_reg  <= '0;
            quo_reg  <= '0;
            cnt_reg  <= '0;
        end else if (state_reg == ST_DIV) begin
            cnt_reg <= cnt_reg + CNT_W'(1);
            if (trial_ge) begin
                rem_reg <= AREA_W'(trial - {1'b0, area_reg});
                quo_reg <= {quo_reg[SUM_W-2:0], 1'b1};
            end else begin
                rem_reg <= AREA_W'(trial);
                quo_reg <= {quo_reg[SUM_W-2:0], 1'b0};
            end
        end
    end

    assign result.busy  = (state_reg != ST_IDLE);
    assign result.scale = scale_reg;
    assign result.shift = shift_reg;

endmodule

@@ sv/wad_front.sv @@
`timescale 1ns / 1ps
// Front end: accepts pixel requests, tags window start and end, forms the
// lane products and holds them in a two-entry queue. Depends on wad_pkg.
module wad_front
    import wad_pkg::*;
#(
    parameter int LANES = 4
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [LANES*SAMPLE_W-1:0]          s_tdata,
    input  logic                               s_tlast,
    input  derive_t                            derived,
    input  logic                               explicit_mode,
    input  logic [SAMPLE_W-1:0]                explicit_scale,
    input  logic [SHIFT_W-1:0]                 explicit_shift,
    input  logic [SUM_W-1:0]                   bias,
    input  logic                               symmetric_saturation,
    input  logic                               pop,
    output logic                               head_valid,
    output item_ctl_t                          head_ctl,
    output logic [LANES-1:0][PROD_W-1:0]       head_prod
);

    item_ctl_t                       ctl_mem [QDEPTH];
    logic [LANES-1:0][PROD_W-1:0]    prod_mem [QDEPTH];
    logic [QPTR_W-1:0]               wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0]               count_reg, count_next;
    logic                            window_open_reg;

    logic                            push;
    logic signed [PROD_W-1:0]        scale;
    item_ctl_t                       in_ctl;
    logic [LANES-1:0][PROD_W-1:0]    in_prod;

    assign s_tready = !derived.busy && (count_reg != QCNT_W'(QDEPTH));
    assign push     = s_tvalid && s_tready;
    assign scale    = explicit_mode ? PROD_W'($signed(explicit_scale))
                                    : PROD_W'($signed(derived.scale));

    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            in_prod[i] = PROD_W'(PROD_W'($signed(s_tdata[i*SAMPLE_W +: SAMPLE_W])) * scale);
        end
    end

    always_comb begin
        in_ctl.first = !window_open_reg;
        in_ctl.last  = s_tlast;
        in_ctl.sym   = symmetric_saturation;
        in_ctl.shift = explicit_mode ? explicit_shift : derived.shift;
        in_ctl.start = explicit_mode ? bias : '0;
    end

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + QCNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg      <= '0;
            rd_ptr_reg      <= '0;
            count_reg       <= '0;
            window_open_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg      <= wr_ptr_reg + QPTR_W'(1);
                window_open_reg <= !s_tlast;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            ctl_mem[wr_ptr_reg]  <= in_ctl;
            prod_mem[wr_ptr_reg] <= in_prod;
        end
    end

    assign head_valid = (count_reg != '0);
    assign head_ctl   = ctl_mem[rd_ptr_reg];
    assign head_prod  = prod_mem[rd_ptr_reg];

endmodule

@@ sv/wad_back.sv @@
`timescale 1ns / 1ps
// Back end: lane accumulators, then rounding shift and int8 saturation into
// the output register. Depends on wad_pkg.
module wad_back
    import wad_pkg::*;
#(
    parameter int LANES = 4
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               head_valid,
    input  item_ctl_t                          head_ctl,
    input  logic [LANES-1:0][PROD_W-1:0]       head_prod,
    output logic                               pop,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [LANES*SAMPLE_W-1:0]          m_tdata
);

    logic [LANES-1:0][SUM_W-1:0]     sums_reg, sums_next;
    logic [LANES-1:0][SUM_W-1:0]     fin_sum_reg;
    logic [SHIFT_W-1:0]              fin_shift_reg;
    logic                            fin_sym_reg;
    logic                            fin_valid_reg;
    logic                            m_tvalid_reg;
    logic [LANES*SAMPLE_W-1:0]       m_tdata_reg, m_tdata_next;

    logic                            out_free;
    logic                            fin_free;
    logic                            fin_move;

    function automatic logic [SAMPLE_W-1:0] round_sat(input logic [SUM_W-1:0]   sum,
                                                      input logic [SHIFT_W-1:0] sh,
                                                      input logic               sym);
        logic signed [SUM_W:0]    wide;
        logic signed [SUM_W:0]    rnd;
        logic signed [SUM_W:0]    shifted;
        logic signed [SUM_W:0]    hi;
        logic signed [SUM_W:0]    lo;
        wide    = $signed({sum[SUM_W-1], sum});
        rnd     = (sh == '0) ? '0 : ((SUM_W + 1)'(1) <<< (sh - SHIFT_W'(1)));
        shifted = (wide + rnd) >>> sh;
        hi      = (SUM_W + 1)'(OUT_MAX);
        lo      = sym ? (SUM_W + 1)'(OUT_MIN_SYM) : (SUM_W + 1)'(OUT_MIN);
        if (shifted > hi) begin
            return OUT_MAX;
        end else if (shifted < lo) begin
            return lo[SAMPLE_W-1:0];
        end
        return shifted[SAMPLE_W-1:0];
    endfunction

    assign out_free = !m_tvalid_reg || m_tready;
    assign fin_free = !fin_valid_reg || out_free;
    assign fin_move = fin_valid_reg && out_free;
    assign pop      = head_valid && (!head_ctl.last || fin_free);

    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            sums_next[i] = (head_ctl.first ? head_ctl.start : sums_reg[i])
                         + {{(SUM_W - PROD_W){head_prod[i][PROD_W-1]}}, head_prod[i]};
        end
    end

    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            m_tdata_next[i*SAMPLE_W +: SAMPLE_W] =
                round_sat(fin_sum_reg[i], fin_shift_reg, fin_sym_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sums_reg      <= '0;
            fin_valid_reg <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            if (pop) begin
                sums_reg <= sums_next;
            end
            if (pop && head_ctl.last) begin
                fin_valid_reg <= 1'b1;
            end else if (fin_move) begin
                fin_valid_reg <= 1'b0;
            end
            if (fin_move) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop && head_ctl.last) begin
            fin_sum_reg   <= sums_next;
            fin_shift_reg <= head_ctl.shift;
            fin_sym_reg   <= head_ctl.sym;
        end
        if (fin_move) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

@@ sv/int8_window_average_pool.sv @@
`timescale 1ns / 1ps
// Int8 window average pool: one pixel request per cycle unless input is stalled, one
// multiply-accumulate per lane. Window sums pass a final-sum register, then the output
// register. Writing window_height or window_width stalls input while the serial divider
// derives scale and shift. Reset is synchronous: registers take their defaults, sums clear.
// Top level; depends on wad_pkg, wad_derive, wad_front and wad_back.
module int8_window_average_pool
    import wad_pkg::*;
#(
    parameter int LANES           = 4,
    parameter int MAX_WINDOW_SIDE = 16
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    // Fields from bit 0 up: sample_a, sample_b, sample_c, sample_d.
    input  logic [LANES*SAMPLE_W-1:0] s_tdata,
    input  logic                      s_tlast,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // Fields from bit 0 up: average_a, average_b, average_c, average_d.
    output logic [LANES*SAMPLE_W-1:0] m_tdata,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [4:0]                paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);

    logic [SIDE_REG_W-1:0]     height_reg;
    logic [SIDE_REG_W-1:0]     width_reg;
    logic                      mode_reg;
    logic [SAMPLE_W-1:0]       scale_reg;
    logic [SHIFT_W-1:0]        shift_reg;
    logic [SUM_W-1:0]          bias_reg;
    logic                      sym_reg;

    logic                      cfg_write;
    reg_index_t                cfg_index;
    logic                      derive_start;
    derive_t                   derived;
    logic                      pop;
    logic                      head_valid;
    item_ctl_t                 head_ctl;
    logic [LANES-1:0][PROD_W-1:0] head_prod;

    assign pready       = 1'b1;
    assign cfg_write    = psel && penable && pwrite && pready;
    assign cfg_index    = reg_index_t'(paddr[4:2]);
    assign derive_start = cfg_write && (cfg_index == REG_HEIGHT || cfg_index == REG_WIDTH);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            height_reg <= SIDE_REG_W'(2);
            width_reg  <= SIDE_REG_W'(2);
            mode_reg   <= 1'b0;
            scale_reg  <= SAMPLE_W'(1);
            shift_reg  <= '0;
            bias_reg   <= '0;
            sym_reg    <= 1'b0;
        end else if (cfg_write) begin
            case (cfg_index)
                REG_HEIGHT: height_reg <= pwdata[SIDE_REG_W-1:0];
                REG_WIDTH:  width_reg  <= pwdata[SIDE_REG_W-1:0];
                REG_MODE:   mode_reg   <= pwdata[0];
                REG_SCALE:  scale_reg  <= pwdata[SAMPLE_W-1:0];
                REG_SHIFT:  shift_reg  <= pwdata[SHIFT_W-1:0];
                REG_BIAS:   bias_reg   <= pwdata;
                REG_SYM:    sym_reg    <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_index)
            REG_HEIGHT: prdata = 32'(height_reg);
            REG_WIDTH:  prdata = 32'(width_reg);
            REG_MODE:   prdata = 32'(mode_reg);
            REG_SCALE:  prdata = 32'(scale_reg);
            REG_SHIFT:  prdata = 32'(shift_reg);
            REG_BIAS:   prdata = bias_reg;
            REG_SYM:    prdata = 32'(sym_reg);
            default:    prdata = '0;
        endcase
    end

    wad_derive #(
        .MAX_WINDOW_SIDE(MAX_WINDOW_SIDE)
    ) u_derive (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (derive_start),
        .height  (height_reg),
        .width   (width_reg),
        .result  (derived)
    );

    wad_front #(
        .LANES(LANES)
    ) u_front (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .s_tvalid             (s_tvalid),
        .s_tready             (s_tready),
        .s_tdata              (s_tdata),
        .s_tlast              (s_tlast),
        .derived              (derived),
        .explicit_mode        (mode_reg),
        .explicit_scale       (scale_reg),
        .explicit_shift       (shift_reg),
        .bias                 (bias_reg),
        .symmetric_saturation (sym_reg),
        .pop                  (pop),
        .head_valid           (head_valid),
        .head_ctl             (head_ctl),
        .head_prod            (head_prod)
    );

    wad_back #(
        .LANES(LANES)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_ctl   (head_ctl),
        .head_prod  (head_prod),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

    assert property (@(posedge aclk) disable iff (!aresetn)
        derived.busy |-> !s_tready)
        else $error("input request accepted while scale derivation runs");

    assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> head_valid)
        else $error("back end popped an empty queue");

    assert property (@(posedge aclk) disable iff (!aresetn)
        derive_start |=> derived.busy)
        else $error("window size write did not start derivation");

endmodule
